// ----- hdl/lfse_pkg.sv -----
package lfse_pkg;

	localparam int VALUE_W = 32;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_ADD  = 2'd2;
	localparam logic [1:0] OP_REV  = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] value;
	} res_info_t;

endpackage

// ----- hdl/lfse_mem.sv -----
module lfse_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- hdl/lfse_ctrl.sv -----
module lfse_ctrl #(
	parameter int STORE_DEPTH = 64,
	parameter int ADDR_W      = 6,
	parameter int CNT_W       = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_order,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 in_op,
	input  logic [lfse_pkg::VALUE_W-1:0] in_value,
	input  logic                       res_free,
	output logic                       res_valid,
	output lfse_pkg::res_info_t        res_info,
	output logic [CNT_W-1:0]           res_depth,
	output logic                       mem_en,
	output logic                       mem_we,
	output logic [ADDR_W-1:0]          mem_addr,
	output logic [lfse_pkg::VALUE_W-1:0] mem_wdata,
	input  logic [lfse_pkg::VALUE_W-1:0] mem_rdata
);
	import lfse_pkg::*;

	localparam int SUM_W = ADDR_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(STORE_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_POP   = 2'd1;
	localparam logic [1:0] ST_ADD_B = 2'd2;
	localparam logic [1:0] ST_ADD_A = 2'd3;

	logic [1:0]         state_q;
	logic [ADDR_W-1:0]  front_q;
	logic [CNT_W-1:0]   count_q;
	logic               rev_q;
	logic [VALUE_W-1:0] b_q;

	logic               accept;
	logic               at_front;
	logic [ADDR_W-1:0]  front_nxt;
	logic [ADDR_W-1:0]  front_prv;
	logic [SUM_W-1:0]   tail_sum;
	logic [SUM_W-1:0]   last_sum;
	logic [ADDR_W-1:0]  tail_addr;
	logic [ADDR_W-1:0]  last_addr;
	logic [ADDR_W-1:0]  pop_addr;
	logic [ADDR_W-1:0]  push_addr;

	// ring address arithmetic
	always_comb begin
		front_nxt = (front_q == LAST_A) ? '0 : front_q + ADDR_W'(1);
		front_prv = (front_q == '0) ? LAST_A : front_q - ADDR_W'(1);
		tail_sum  = {1'b0, front_q} + SUM_W'(count_q);
		last_sum  = tail_sum - SUM_W'(1);
		tail_addr = (tail_sum >= DEPTH_S) ? ADDR_W'(tail_sum - DEPTH_S) : tail_sum[ADDR_W-1:0];
		last_addr = (last_sum >= DEPTH_S) ? ADDR_W'(last_sum - DEPTH_S) : last_sum[ADDR_W-1:0];
		at_front  = pop_order ^ rev_q;
		pop_addr  = at_front ? front_q : last_addr;
		push_addr = rev_q ? front_prv : tail_addr;
	end

	assign in_ready = (state_q == ST_IDLE) && res_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mem_en          = 1'b0;
		mem_we          = 1'b0;
		mem_addr        = pop_addr;
		mem_wdata       = in_value;
		res_valid       = 1'b0;
		res_info.status = STATUS_OK;
		res_info.value  = '0;
		res_depth       = count_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_PUSH: begin
							res_valid = 1'b1;
							if (count_q == FULL_C) begin
								res_info.status = STATUS_FULL;
							end else begin
								mem_en    = 1'b1;
								mem_we    = 1'b1;
								mem_addr  = push_addr;
								res_depth = count_q + ONE_C;
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								res_valid       = 1'b1;
								res_info.status = STATUS_EMPTY;
							end else begin
								mem_en = 1'b1;
							end
						end
						OP_ADD: begin
							if (count_q == '0) begin
								res_valid       = 1'b1;
								res_info.status = STATUS_EMPTY;
							end else if (count_q == ONE_C) begin
								res_valid       = 1'b1;
								res_info.status = STATUS_EMPTY;
								res_depth       = '0;
							end else begin
								mem_en = 1'b1;
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				res_valid      = 1'b1;
				res_info.value = mem_rdata;
			end
			ST_ADD_B: begin
				mem_en = 1'b1;
			end
			ST_ADD_A: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = push_addr;
				mem_wdata = mem_rdata + b_q;
				res_valid = 1'b1;
				res_depth = count_q + ONE_C;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_PUSH: begin
								if (count_q != FULL_C) begin
									if (rev_q) begin
										front_q <= front_prv;
									end
									count_q <= count_q + ONE_C;
								end
							end
							OP_POP: begin
								if (count_q != '0) begin
									if (at_front) begin
										front_q <= front_nxt;
									end
									count_q <= count_q - ONE_C;
									state_q <= ST_POP;
								end
							end
							OP_ADD: begin
								if (count_q != '0) begin
									if (at_front) begin
										front_q <= front_nxt;
									end
									count_q <= count_q - ONE_C;
									if (count_q != ONE_C) begin
										state_q <= ST_ADD_B;
									end
								end
							end
							default: begin
								rev_q <= ~rev_q;
							end
						endcase
					end
				end
				ST_POP: begin
					state_q <= ST_IDLE;
				end
				ST_ADD_B: begin
					if (at_front) begin
						front_q <= front_nxt;
					end
					count_q <= count_q - ONE_C;
					state_q <= ST_ADD_A;
				end
				ST_ADD_A: begin
					if (rev_q) begin
						front_q <= front_prv;
					end
					count_q <= count_q + ONE_C;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// first operand of add, read back in the cycle after its address
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD_B) begin
			b_q <= mem_rdata;
		end
	end

endmodule

// ----- hdl/lifo_fifo_int_stack_engine.sv -----
// Integer stack/queue on one single-port memory of STORE_DEPTH 32-bit entries. The cfg
// register picks pop order: 0 pops the newest element, 1 the oldest. s_tuser carries the
// op (push, pop, add of the two popped values, reverse), s_tdata the push value. Each
// transfer in gives one transfer out with status, popped value and depth after the step.
// A new op is taken only in the idle state. Push, reverse and failing ops finish there; a
// pop also passes the pop state, and an add the states that read its second operand and
// write back the sum, since each element read goes through the registered memory port. The
// result sits in an output register; an op is taken only in a cycle where that register is
// empty or its result is taken, so a result held by m_tready low stalls the input.
module lifo_fifo_int_stack_engine #(
	parameter int STORE_DEPTH = 64,
	localparam int ADDR_W = $clog2(STORE_DEPTH),
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1),
	localparam int OUT_DW = lfse_pkg::VALUE_W + CNT_W,
	localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lfse_pkg::VALUE_W-1:0] s_tdata,  // push_value
	input  logic [1:0]                   s_tuser,  // op
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_TW-1:0]            m_tdata,  // popped_value, depth
	output logic [1:0]                   m_tuser,  // status
	input  logic                         cfg_we,
	input  logic                         cfg_wdata
);
	import lfse_pkg::*;

	logic               pop_order_q;
	logic               m_valid_q;
	res_info_t          m_info_q;
	logic [CNT_W-1:0]   m_depth_q;

	logic               res_free;
	logic               res_valid;
	res_info_t          res_info;
	logic [CNT_W-1:0]   res_depth;
	logic               mem_en;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_addr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [VALUE_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_order_q <= 1'b0;
		end else if (cfg_we) begin
			pop_order_q <= cfg_wdata;
		end
	end

	assign res_free = !m_valid_q || m_tready;

	lfse_ctrl #(
		.STORE_DEPTH (STORE_DEPTH),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_order (pop_order_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_value  (s_tdata),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res_info  (res_info),
		.res_depth (res_depth),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	lfse_mem #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (VALUE_W)
	) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_info_q  <= res_info;
			m_depth_q <= res_depth;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TW'({m_depth_q, m_info_q.value});
	assign m_tuser  = m_info_q.status;

endmodule

// ----- sim/lifo_fifo_int_stack_engine_tb.sv -----
module lifo_fifo_int_stack_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfse_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int OUT_TW = ((VALUE_W + CNT_W + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   depth;
	} stack_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata = '0;  // push_value
	logic [1:0]         s_tuser = OP_PUSH;  // op
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_TW-1:0]  m_tdata;  // popped_value, depth
	logic [1:0]         m_tuser;  // status
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;

	// shadow copy of the store
	logic [VALUE_W-1:0] elem_mem [STORE_DEPTH];
	logic [ADDR_W-1:0]  front_ptr;
	logic [CNT_W-1:0]   elem_cnt;
	logic               rev_flag;
	logic               pop_oldest;

	stack_result_t pending_results [$];
	stack_result_t want_res;

	int  errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_full = 0;
	int  n_empty = 0;
	int  quiet_cycles = 0;
	bit  no_gaps = 1'b0;
	bit  rx_no_stall = 1'b0;
	bit  hold_req = 1'b0;
	bit  holding = 1'b0;

	lifo_fifo_int_stack_engine #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit store_push(logic [VALUE_W-1:0] v);
		logic [ADDR_W-1:0] addr;
		if (elem_cnt >= STORE_DEPTH)
			return 1'b0;
		if (rev_flag) begin
			front_ptr = front_ptr - 1'b1;
			elem_mem[front_ptr] = v;
		end else begin
			addr = front_ptr + elem_cnt[ADDR_W-1:0];
			elem_mem[addr] = v;
		end
		elem_cnt++;
		return 1'b1;
	endfunction

	function automatic bit store_pop(output logic [VALUE_W-1:0] v);
		logic [ADDR_W-1:0] addr;
		v = '0;
		if (elem_cnt == 0)
			return 1'b0;
		// oldest sits at the front in normal order, newest when reversed
		if (pop_oldest ^ rev_flag) begin
			v = elem_mem[front_ptr];
			front_ptr = front_ptr + 1'b1;
		end else begin
			addr = front_ptr + elem_cnt[ADDR_W-1:0] - 1'b1;
			v = elem_mem[addr];
		end
		elem_cnt--;
		return 1'b1;
	endfunction

	function automatic stack_result_t predict_stack_op(logic [1:0] op, logic [VALUE_W-1:0] val);
		stack_result_t      r;
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
		logic [VALUE_W-1:0] got;
		bit                 ok_a;
		bit                 ok_b;
		r.status = STATUS_OK;
		r.value = '0;
		case (op)
			OP_PUSH: begin
				if (!store_push(val))
					r.status = STATUS_FULL;
			end
			OP_POP: begin
				if (store_pop(got))
					r.value = got;
				else
					r.status = STATUS_EMPTY;
			end
			OP_ADD: begin
				ok_b = store_pop(b);
				ok_a = store_pop(a);
				if (ok_b && ok_a)
					void'(store_push(a + b));
				else
					r.status = STATUS_EMPTY;
			end
			default: begin
				rev_flag = ~rev_flag;
			end
		endcase
		r.depth = elem_cnt;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 39))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(logic [1:0] op, logic [VALUE_W-1:0] val);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_stack_op(op, val));
		n_sent++;
	endtask

	task automatic idle_bus();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_pop_order(logic v);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		pop_oldest = v;
	endtask

	task automatic test_empty_and_wrap();
		write_pop_order(1'b0);
		send_op(OP_POP, 32'h1234_5678);
		send_op(OP_ADD, 32'hffff_ffff);
		send_op(OP_REV, 32'h0000_0000);
		send_op(OP_REV, 32'hffff_ffff);
		// add with a single element loses it
		send_op(OP_PUSH, 32'h7fff_ffff);
		send_op(OP_ADD, 32'h0);
		send_op(OP_PUSH, 32'h7fff_ffff);
		send_op(OP_PUSH, 32'h0000_0001);
		send_op(OP_ADD, 32'h0);
		send_op(OP_PUSH, 32'h8000_0000);
		send_op(OP_ADD, 32'h0);
		send_op(OP_POP, 32'h0);
		send_op(OP_PUSH, 32'hffff_ffff);
		send_op(OP_PUSH, 32'h0000_0005);
		send_op(OP_POP, 32'h0);
		send_op(OP_REV, 32'h0);
		send_op(OP_PUSH, 32'h0000_0007);
		send_op(OP_POP, 32'h0);
		send_op(OP_POP, 32'h0);
		send_op(OP_POP, 32'h0);
		send_op(OP_PUSH, 32'haaaa_aaaa);
		send_op(OP_PUSH, 32'h5555_5555);
		send_op(OP_REV, 32'h0);
		send_op(OP_ADD, 32'h0);
		send_op(OP_POP, 32'h0);
		idle_bus();
	endtask

	task automatic test_fifo_order();
		write_pop_order(1'b1);
		send_op(OP_PUSH, 32'd1);
		send_op(OP_PUSH, 32'd2);
		send_op(OP_PUSH, 32'd3);
		send_op(OP_POP, 32'h0);
		send_op(OP_REV, 32'h0);
		send_op(OP_POP, 32'h0);
		send_op(OP_PUSH, 32'd9);
		send_op(OP_ADD, 32'h0);
		send_op(OP_POP, 32'h0);
		send_op(OP_POP, 32'h0);
		idle_bus();
	endtask

	task automatic test_full_store();
		repeat (STORE_DEPTH) send_op(OP_PUSH, pick_value());
		send_op(OP_PUSH, pick_value());
		send_op(OP_REV, $urandom);
		send_op(OP_PUSH, pick_value());
		send_op(OP_ADD, $urandom);
		send_op(OP_PUSH, pick_value());
		repeat (30) send_op(OP_POP, $urandom);
		idle_bus();
		write_pop_order(1'b0);
		repeat (STORE_DEPTH - 30) send_op(OP_POP, $urandom);
		idle_bus();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		while (!holding)
			@(posedge clk);
		no_gaps = 1'b1;
		repeat (20) send_op(OP_PUSH, pick_value());
		no_gaps = 1'b0;
		repeat (20) send_op(OP_POP, $urandom);
		idle_bus();
	endtask

	task automatic test_random_mix();
		int push_pct;
		int r;
		for (int ph = 0; ph < 4; ph++) begin
			write_pop_order(~ph[0]);
			no_gaps = (ph == 2);
			rx_no_stall = (ph == 2);
			repeat (5) begin
				case ($urandom_range(0, 3))
					0: push_pct = 15;
					1: push_pct = 40;
					2: push_pct = 60;
					default: push_pct = 88;
				endcase
				repeat (10) begin
					r = $urandom_range(0, 99);
					if (r < push_pct)
						send_op(OP_PUSH, pick_value());
					else if (r < push_pct + (100 - push_pct) * 55 / 100)
						send_op(OP_POP, $urandom);
					else if (r < push_pct + (100 - push_pct) * 85 / 100)
						send_op(OP_ADD, $urandom);
					else
						send_op(OP_REV, $urandom);
				end
			end
			no_gaps = 1'b0;
			rx_no_stall = 1'b0;
			idle_bus();
		end
	endtask

	// result side ready/stall pattern, plus the long hold for backpressure
	initial begin
		int run;
		int stall;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
				hold_req = 1'b0;
			end else begin
				m_tready <= 1'b1;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
				repeat (run) @(posedge clk);
				stall = rx_no_stall ? 0 : pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 20)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: unexpected result transfer, expected none, actual status %0d",
						$time, m_tuser);
			end else begin
				want_res = pending_results.pop_front();
				compare_field("status", 32'(want_res.status), 32'(m_tuser));
				compare_field("popped value", want_res.value, m_tdata[VALUE_W-1:0]);
				compare_field("depth", 32'(want_res.depth), 32'(m_tdata[VALUE_W +: CNT_W]));
				n_checked++;
				if (want_res.status == STATUS_FULL)
					n_full++;
				if (want_res.status == STATUS_EMPTY)
					n_empty++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_results.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		front_ptr = '0;
		elem_cnt = '0;
		rev_flag = 1'b0;
		pop_oldest = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_wrap();
		test_fifo_order();
		test_full_store();
		test_backpressure();
		test_random_mix();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered push/pop/add/reverse in both pop orders, %0d ops sent, %0d results checked",
			n_sent, n_checked);
		$display("%0d results hit a full store, %0d an empty one, %0d mismatches",
			n_full, n_empty, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/lfse_pkg.sv
hdl/lfse_mem.sv
hdl/lfse_ctrl.sv
hdl/lifo_fifo_int_stack_engine.sv
sim/lifo_fifo_int_stack_engine_tb.sv
